FILE: design/i2cme_pkg.sv
// ----------------------------------------------------------------------------
// i2cme_pkg
// shared types and constants for the i2c master message engine
// ----------------------------------------------------------------------------
package i2cme_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_S1   = 4'd1,
    PH_S2   = 4'd2,
    PH_WLO  = 4'd3,
    PH_WHI  = 4'd4,
    PH_WALO = 4'd5,
    PH_WAHI = 4'd6,
    PH_RLO  = 4'd7,
    PH_RHI  = 4'd8,
    PH_RALO = 4'd9,
    PH_RAHI = 4'd10,
    PH_P0   = 4'd11,
    PH_P1   = 4'd12,
    PH_P2   = 4'd13
  } phase_t;

  typedef enum logic [1:0] {
    STAGE_ADDR0 = 2'd0,
    STAGE_ADDR1 = 2'd1,
    STAGE_LEN   = 2'd2,
    STAGE_DATA  = 2'd3
  } stage_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NAK  = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  localparam logic [7:0] TEN_BIT_HDR = 8'hF0;
  localparam logic [15:0] HP_RESET = 16'd250;

  // one queued item, already decoded by the front part
  typedef struct packed {
    mode_t       mode;
    logic [9:0]  addr;
    logic        read_dir;
    logic        ten_bit;
    logic        no_start;
    logic        ignore_nak;
    logic        recv_len;
    logic        stop_after;
    logic [8:0]  length;
    logic [7:0]  data_byte;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_last;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

FILE: design/i2cme_queue.sv
// ----------------------------------------------------------------------------
// i2cme_queue
// small two-entry register queue used between the pipeline parts
// ----------------------------------------------------------------------------
module i2cme_queue import i2cme_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: design/i2cme_engine.sv
// ----------------------------------------------------------------------------
// i2cme_engine
// back part: bus sequencer, timing counter, transmit buffer
// ----------------------------------------------------------------------------
module i2cme_engine import i2cme_pkg::*; #(
  parameter int MAX_BYTES = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   half_period_ticks,
  input  logic          in_valid,
  input  item_t         in_item,
  output logic          in_ready,
  output logic          out_valid,
  output result_t       out_res,
  input  logic          out_ready
);

  localparam logic [8:0] MAXB = 9'(MAX_BYTES > 511 ? 511 : MAX_BYTES);
  localparam logic [16:0] MAXF = 17'(MAX_BYTES);

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [8:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [8:0]  read_count, read_count_next;
  logic [9:0]  opt_addr, opt_addr_next;
  logic        opt_read, opt_ten, opt_ign, opt_rlen, opt_stop;
  logic        opt_read_next, opt_ten_next, opt_ign_next, opt_rlen_next, opt_stop_next;
  logic        error_flag, error_flag_next;
  logic [16:0] tx_fill, tx_fill_next;
  logic        scl, scl_next, sda, sda_next;
  stage_t      stage, stage_next;

  logic [7:0]  tx_store [MAX_BYTES];
  logic [7:0]  tx_rd;
  logic [8:0]  tx_rd_idx;
  logic        tx_rd_ok;
  logic        tx_we;
  logic        rxv, rxl, done;
  logic [7:0]  rxd;
  logic [1:0]  status;
  logic        fire;
  logic [15:0] hp;
  logic        ack;
  logic [8:0]  rem;
  logic [8:0]  len_c;
  logic [8:0]  nbi;

  // the engine steps only when the result slot is free or being emptied
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign hp       = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;

  // the next byte to send is fetched ahead into a register: entry 0 outside a data
  // stage, the entry after the current one during a data stage
  always_comb begin
    tx_rd_idx = 9'd0;
    if (phase_next != PH_IDLE && stage_next == STAGE_DATA) begin
      tx_rd_idx = byte_index_next + 9'd1;
    end
  end

  assign tx_rd_ok = (32'(tx_rd_idx) < MAX_BYTES);

  always_ff @(posedge clk) begin
    if (tx_we) tx_store[tx_fill[AW-1:0]] <= in_item.data_byte;
    // a load into the entry being fetched is passed straight through
    if (tx_we && tx_fill == 17'(tx_rd_idx)) tx_rd <= in_item.data_byte;
    else if (tx_rd_ok) tx_rd <= tx_store[AW'(tx_rd_idx)];
    else tx_rd <= 8'd0;
  end

  always_comb begin
    phase_next = phase; tick_count_next = tick_count; bit_index_next = bit_index;
    byte_index_next = byte_index; shift_byte_next = shift_byte;
    read_count_next = read_count; opt_addr_next = opt_addr;
    opt_read_next = opt_read; opt_ten_next = opt_ten; opt_ign_next = opt_ign;
    opt_rlen_next = opt_rlen; opt_stop_next = opt_stop;
    error_flag_next = error_flag; tx_fill_next = tx_fill;
    scl_next = scl; sda_next = sda; stage_next = stage;
    rxv = 1'b0; rxl = 1'b0; rxd = 8'd0; done = 1'b0; status = ST_OK;
    tx_we = 1'b0; ack = 1'b0; rem = 9'd0; len_c = 9'd0;
    nbi = byte_index + 9'd1;
    if (fire) begin
      case (in_item.mode)
        MODE_START, MODE_LOAD: begin
          if (phase != PH_IDLE) begin
            status = ST_BUSY;
          end else if (in_item.mode == MODE_LOAD) begin
            if (tx_fill < MAXF) begin
              tx_we = 1'b1;
              tx_fill_next = tx_fill + 17'd1;
            end
          end else begin
            len_c = (in_item.length > MAXB) ? MAXB : in_item.length;
            opt_addr_next = in_item.addr; opt_read_next = in_item.read_dir;
            opt_ten_next = in_item.ten_bit; opt_ign_next = in_item.ignore_nak;
            opt_rlen_next = in_item.recv_len; opt_stop_next = in_item.stop_after;
            read_count_next = len_c; error_flag_next = 1'b0;
            tick_count_next = 16'd0; bit_index_next = 4'd0;
            byte_index_next = 9'd0; shift_byte_next = 8'd0;
            stage_next = STAGE_ADDR0;
            if (in_item.no_start) begin
              // skip the start condition and address
              if (in_item.read_dir && in_item.recv_len) begin
                stage_next = STAGE_LEN; shift_byte_next = 8'd0; scl_next = 1'b0;
                sda_next = 1'b1; phase_next = PH_RLO;
              end else if (len_c == 9'd0) begin
                if (in_item.stop_after) begin
                  scl_next = 1'b0; sda_next = 1'b0; phase_next = PH_P0;
                end else begin
                  phase_next = PH_IDLE; done = 1'b1; tx_fill_next = 17'd0;
                end
              end else if (in_item.read_dir) begin
                stage_next = STAGE_DATA; scl_next = 1'b0; sda_next = 1'b1;
                phase_next = PH_RLO;
              end else begin
                stage_next = STAGE_DATA; shift_byte_next = tx_rd;
                scl_next = 1'b0; sda_next = tx_rd[7]; phase_next = PH_WLO;
              end
            end else begin
              sda_next = 1'b1; scl_next = 1'b1; phase_next = PH_S1;
            end
          end
        end
        MODE_TICK: begin
          if (phase != PH_IDLE) begin
            if (tick_count + 16'd1 >= hp) begin
              tick_count_next = 16'd0;
              case (phase)
                PH_S1: begin sda_next = 1'b0; phase_next = PH_S2; end
                PH_S2: begin
                  stage_next = STAGE_ADDR0; bit_index_next = 4'd0;
                  scl_next = 1'b0; phase_next = PH_WLO;
                  if (opt_ten) shift_byte_next = TEN_BIT_HDR |
                      {5'd0, opt_addr[9:8], opt_read};
                  else shift_byte_next = {opt_addr[6:0], opt_read};
                  sda_next = shift_byte_next[7];
                end
                PH_WLO: begin scl_next = 1'b1; phase_next = PH_WHI; end
                PH_WHI: begin
                  scl_next = 1'b0;
                  bit_index_next = bit_index + 4'd1;
                  if (bit_index_next < 4'd8) begin
                    sda_next = shift_byte[3'(4'd7 - bit_index_next)];
                    phase_next = PH_WLO;
                  end else begin
                    sda_next = 1'b1; phase_next = PH_WALO;
                  end
                end
                PH_WALO: begin scl_next = 1'b1; phase_next = PH_WAHI; end
                PH_WAHI: begin
                  scl_next = 1'b0;
                  ack = !in_item.sda_in;
                  bit_index_next = 4'd0;
                  if (stage == STAGE_ADDR0 || stage == STAGE_ADDR1) begin
                    if (!ack) begin
                      if (!opt_ign) error_flag_next = 1'b1;
                      sda_next = 1'b0; phase_next = PH_P0;
                    end else if (stage == STAGE_ADDR0 && opt_ten) begin
                      stage_next = STAGE_ADDR1;
                      shift_byte_next = opt_addr[7:0];
                      sda_next = opt_addr[7]; phase_next = PH_WLO;
                    end else begin
                      byte_index_next = 9'd0;
                      if (opt_read && opt_rlen) begin
                        stage_next = STAGE_LEN; shift_byte_next = 8'd0;
                        sda_next = 1'b1; phase_next = PH_RLO;
                      end else if (read_count == 9'd0) begin
                        if (opt_stop) begin
                          sda_next = 1'b0; phase_next = PH_P0;
                        end else begin
                          phase_next = PH_IDLE; done = 1'b1; tx_fill_next = 17'd0;
                        end
                      end else if (opt_read) begin
                        stage_next = STAGE_DATA; shift_byte_next = 8'd0;
                        sda_next = 1'b1; phase_next = PH_RLO;
                      end else begin
                        stage_next = STAGE_DATA;
                        shift_byte_next = tx_rd; sda_next = tx_rd[7];
                        phase_next = PH_WLO;
                      end
                    end
                  end else if (!ack && !opt_ign) begin
                    error_flag_next = 1'b1; sda_next = 1'b0; phase_next = PH_P0;
                  end else begin
                    byte_index_next = nbi;
                    if (nbi < read_count) begin
                      shift_byte_next = tx_rd; sda_next = tx_rd[7];
                      phase_next = PH_WLO;
                    end else if (opt_stop) begin
                      sda_next = 1'b0; phase_next = PH_P0;
                    end else begin
                      phase_next = PH_IDLE; done = 1'b1; tx_fill_next = 17'd0;
                    end
                  end
                end
                PH_RLO: begin
                  if (bit_index < 4'd8) begin
                    scl_next = 1'b1; phase_next = PH_RHI;
                  end else begin
                    ack = (stage == STAGE_LEN) || (nbi < read_count);
                    sda_next = !ack; phase_next = PH_RALO;
                  end
                end
                PH_RHI: begin
                  shift_byte_next = {shift_byte[6:0], in_item.sda_in};
                  bit_index_next = bit_index + 4'd1;
                  scl_next = 1'b0; phase_next = PH_RLO;
                end
                PH_RALO: begin scl_next = 1'b1; phase_next = PH_RAHI; end
                PH_RAHI: begin
                  scl_next = 1'b0; sda_next = 1'b1;
                  rxv = 1'b1; rxd = shift_byte;
                  bit_index_next = 4'd0; shift_byte_next = 8'd0;
                  if (stage == STAGE_LEN) begin
                    if (read_count != 9'd0)
                      rem = ({1'b0, shift_byte} < read_count - 9'd1) ?
                            {1'b0, shift_byte} : read_count - 9'd1;
                    read_count_next = rem; byte_index_next = 9'd0;
                    rxl = (rem == 9'd0);
                    if (rem == 9'd0) begin
                      if (opt_stop) begin
                        sda_next = 1'b0; phase_next = PH_P0;
                      end else begin
                        phase_next = PH_IDLE; done = 1'b1; tx_fill_next = 17'd0;
                      end
                    end else begin
                      stage_next = STAGE_DATA; phase_next = PH_RLO;
                    end
                  end else begin
                    byte_index_next = nbi;
                    rxl = (nbi >= read_count);
                    if (!rxl) begin
                      phase_next = PH_RLO;
                    end else if (opt_stop) begin
                      sda_next = 1'b0; phase_next = PH_P0;
                    end else begin
                      phase_next = PH_IDLE; done = 1'b1; tx_fill_next = 17'd0;
                    end
                  end
                end
                PH_P0: begin scl_next = 1'b1; phase_next = PH_P1; end
                PH_P1: begin sda_next = 1'b1; phase_next = PH_P2; end
                PH_P2: begin
                  phase_next = PH_IDLE; done = 1'b1; tx_fill_next = 17'd0;
                end
                default: phase_next = PH_IDLE;
              endcase
            end else begin
              tick_count_next = tick_count + 16'd1;
            end
          end
        end
        default: ;
      endcase
      if (done) status = error_flag_next ? ST_NAK : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; tick_count <= 16'd0; bit_index <= 4'd0;
      byte_index <= 9'd0; shift_byte <= 8'd0; read_count <= 9'd0;
      opt_addr <= 10'd0; opt_read <= 1'b0; opt_ten <= 1'b0; opt_ign <= 1'b0;
      opt_rlen <= 1'b0; opt_stop <= 1'b0; error_flag <= 1'b0;
      tx_fill <= 17'd0; scl <= 1'b1; sda <= 1'b1; stage <= STAGE_ADDR0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next; tick_count <= tick_count_next;
      bit_index <= bit_index_next; byte_index <= byte_index_next;
      shift_byte <= shift_byte_next; read_count <= read_count_next;
      opt_addr <= opt_addr_next; opt_read <= opt_read_next;
      opt_ten <= opt_ten_next; opt_ign <= opt_ign_next;
      opt_rlen <= opt_rlen_next; opt_stop <= opt_stop_next;
      error_flag <= error_flag_next; tx_fill <= tx_fill_next;
      scl <= scl_next; sda <= sda_next; stage <= stage_next;
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res.scl_level <= scl_next;
      out_res.sda_level <= sda_next;
      out_res.busy_res  <= (phase_next != PH_IDLE);
      out_res.rx_valid  <= rxv;
      out_res.rx_data   <= rxd;
      out_res.rx_last   <= rxl;
      out_res.done_res  <= done;
      out_res.status    <= status;
    end
  end

endmodule

FILE: design/i2c_master_message_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_message_engine_unit
// i2c master running one message at a time, while results are popped one item per clock
// ----------------------------------------------------------------------------
// path: an item waits in the input queue, then the sequencer step loads the
//   result register, which drives the result ports; the result waits there
//   while the result side stalls
// throughput: one item per cycle while results are popped, one per sequencer step
// reset: synchronous active-high rst; lines released high, sequencer idle,
//   transmit buffer empty, half period back to 250 ticks
module i2c_master_message_engine_unit import i2cme_pkg::*; #(
  parameter int MAX_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // item input queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [9:0]  addr,
  input  logic        read_dir,
  input  logic        ten_bit,
  input  logic        no_start,
  input  logic        ignore_nak,
  input  logic        recv_len,
  input  logic        stop_after,
  input  logic [8:0]  length,
  input  logic [7:0]  data_byte,
  input  logic        sda_in,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        rx_valid,
  output logic [7:0]  rx_data,
  output logic        rx_last,
  output logic        done_res,
  output logic [1:0]  status,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [15:0] half_period_ticks;
  item_t       in_item;
  item_t       q_item;
  logic        q_empty;
  logic        eng_ready;
  logic        eng_valid;
  result_t     eng_res;

  // register file: single half period register at offset 0
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, half_period_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HP_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      half_period_ticks <= pwdata[15:0];
    end
  end

  // front part: pack and queue incoming items
  always_comb begin
    in_item.mode       = mode_t'(mode);
    in_item.addr       = addr;
    in_item.read_dir   = read_dir;
    in_item.ten_bit    = ten_bit;
    in_item.no_start   = no_start;
    in_item.ignore_nak = ignore_nak;
    in_item.recv_len   = recv_len;
    in_item.stop_after = stop_after;
    in_item.length     = length;
    in_item.data_byte  = data_byte;
    in_item.sda_in     = sda_in;
  end

  i2cme_queue #(.WIDTH($bits(item_t))) u_in_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (in_item),
    .full      (full),
    .pop       (eng_ready),
    .pop_data  (q_item),
    .empty     (q_empty)
  );

  // back part: bus sequencer with its result register
  i2cme_engine #(.MAX_BYTES(MAX_BYTES), .AW(AW)) u_engine (
    .clk               (clk),
    .rst               (rst),
    .half_period_ticks (half_period_ticks),
    .in_valid          (!q_empty),
    .in_item           (q_item),
    .in_ready          (eng_ready),
    .out_valid         (eng_valid),
    .out_res           (eng_res),
    .out_ready         (pop)
  );

  // result register is the head of the output queue
  assign empty     = !eng_valid;
  assign scl_level = eng_res.scl_level;
  assign sda_level = eng_res.sda_level;
  assign busy_res  = eng_res.busy_res;
  assign rx_valid  = eng_res.rx_valid;
  assign rx_data   = eng_res.rx_data;
  assign rx_last   = eng_res.rx_last;
  assign done_res  = eng_res.done_res;
  assign status    = eng_res.status;

endmodule
